// ===== hw/rtl/liwp_pkg.sv =====
// ----------------------------------------------------------------------------
// liwp_pkg
// Shared types, constants and functions of the line index random word picker:
// action codes, controller states, command/status bundles and xorshift32 step.
// ----------------------------------------------------------------------------
`default_nettype none

package liwp_pkg;

  // default sizes
  localparam int unsigned DEF_MAX_WORDS    = 8192;
  localparam int unsigned DEF_MAX_WORD_LEN = 96;
  localparam int unsigned DEF_OFFSET_BITS  = 20;

  // random state
  localparam int unsigned RNG_W        = 32;
  localparam logic [31:0] RNG_RESET    = 32'hC0DE_F00D;
  localparam logic [31:0] RNG_ZERO_FIX = 32'hA5A5_A5A5;
  localparam logic [31:0] SEED_MIX     = 32'h9E37_79B9;

  // byte codes
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  // register port
  localparam int unsigned APB_AW   = 3;
  localparam logic        REG_SEED = 1'b0;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_BYTE  = 2'd1,
    ACT_END   = 2'd2,
    ACT_PICK  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start_load;
    logic take_byte;
    logic end_load;
    logic pick_go;
    logic pick_fail;
    logic mem_read;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pick_bad;
    logic mod_done;
    logic out_free;
  } stat_t;

  // xorshift32 with shifts 13, 17, 5; zero is replaced
  function automatic logic [31:0] rng_step(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    if (y == 32'd0) begin
      y = RNG_ZERO_FIX;
    end
    return y;
  endfunction

  // fold the time value into the state; zero is replaced
  function automatic logic [31:0] rng_seed(input logic [31:0] x, input logic [31:0] t);
    logic [31:0] y;
    y = x ^ (t << 16) ^ (t >> 3) ^ SEED_MIX;
    if (y == 32'd0) begin
      y = RNG_RESET;
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/liwp_if.sv =====
// ----------------------------------------------------------------------------
// liwp_if
// Valid/ready channels of the word picker: command items in, pick results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface liwp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic [7:0] dest_capacity;

  modport source (output valid, action, data_byte, dest_capacity, input ready);
  modport sink   (input valid, action, data_byte, dest_capacity, output ready);
endinterface

interface liwp_out_if #(
  parameter int unsigned IW = $clog2(liwp_pkg::DEF_MAX_WORDS),
  parameter int unsigned OW = liwp_pkg::DEF_OFFSET_BITS,
  parameter int unsigned LW = $clog2(liwp_pkg::DEF_MAX_WORD_LEN + 1)
);
  logic          valid;
  logic          ready;
  logic          ok;
  logic [IW-1:0] word_index;
  logic [OW-1:0] word_offset;
  logic [LW-1:0] word_length;

  modport source (output valid, ok, word_index, word_offset, word_length, input ready);
  modport sink   (input valid, ok, word_index, word_offset, word_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/liwp_mod.sv =====
// ----------------------------------------------------------------------------
// liwp_mod
// Restoring remainder unit: one dividend bit per cycle, pulses done when the
// remainder of dividend modulo divisor is final.
// ----------------------------------------------------------------------------
`default_nettype none

module liwp_mod #(
  parameter int unsigned DW = 32,
  parameter int unsigned TW = 14,
  parameter int unsigned AW = 13
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [TW-1:0] divisor_i,
  output logic               done_o,
  output logic [AW-1:0]      rem_o
);

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] dvd_q, dvd_d;
  logic [TW-1:0] div_q, div_d;
  logic [TW-1:0] rem_q, rem_d;
  logic [TW:0]   trial;
  logic [TW:0]   diff;

  // one restoring step
  always_comb begin
    trial  = {rem_q, dvd_q[DW-1]};
    diff   = trial - {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[TW-1:0];
      end else begin
        rem_d = trial[TW-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[AW-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/liwp_ctrl.sv =====
// ----------------------------------------------------------------------------
// liwp_ctrl
// Sequencer of the word picker: takes items in idle, walks a pick through the
// remainder unit, table read and output register (a failed pick: output only).
// ----------------------------------------------------------------------------
`default_nettype none

module liwp_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [1:0]     in_action_i,
  output logic                in_ready_o,
  input  wire liwp_pkg::stat_t stat_i,
  output liwp_pkg::cmd_t      cmd_o
);

  liwp_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= liwp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      liwp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (liwp_pkg::action_e'(in_action_i))
            liwp_pkg::ACT_START: cmd_o.start_load = 1'b1;
            liwp_pkg::ACT_BYTE:  cmd_o.take_byte  = 1'b1;
            liwp_pkg::ACT_END:   cmd_o.end_load   = 1'b1;
            liwp_pkg::ACT_PICK: begin
              if (stat_i.pick_bad) begin
                cmd_o.pick_fail = 1'b1;
                state_d         = liwp_pkg::ST_OUT;
              end else begin
                cmd_o.pick_go = 1'b1;
                state_d       = liwp_pkg::ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      liwp_pkg::ST_DIV: begin
        if (stat_i.mod_done) begin
          state_d = liwp_pkg::ST_READ;
        end
      end
      liwp_pkg::ST_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = liwp_pkg::ST_OUT;
      end
      liwp_pkg::ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = liwp_pkg::ST_IDLE;
        end
      end
      default: state_d = liwp_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/liwp_dp.sv =====
// ----------------------------------------------------------------------------
// liwp_dp
// Datapath of the word picker: line scanner, word table memory, random state,
// remainder unit and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module liwp_dp #(
  parameter int unsigned MAX_WORDS    = liwp_pkg::DEF_MAX_WORDS,
  parameter int unsigned MAX_WORD_LEN = liwp_pkg::DEF_MAX_WORD_LEN,
  parameter int unsigned OFFSET_BITS  = liwp_pkg::DEF_OFFSET_BITS,
  parameter int unsigned AW           = $clog2(MAX_WORDS),
  parameter int unsigned LW           = $clog2(MAX_WORD_LEN + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire liwp_pkg::cmd_t         cmd_i,
  output liwp_pkg::stat_t             stat_o,
  input  wire logic [7:0]             data_byte_i,
  input  wire logic [7:0]             dest_capacity_i,
  input  wire logic [31:0]            seed_time_i,
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output logic                        out_ok_o,
  output logic [AW-1:0]               out_index_o,
  output logic [OFFSET_BITS-1:0]      out_offset_o,
  output logic [LW-1:0]               out_length_o
);

  localparam int unsigned TW = $clog2(MAX_WORDS + 1);
  localparam int unsigned OB = OFFSET_BITS;
  localparam int unsigned EW = OB + LW;

  logic [31:0]   rng_q, rng_d;
  logic [TW-1:0] total_q, total_d;
  logic [OB:0]   pos_q, pos_d;
  logic          inside_q, inside_d;
  logic [OB-1:0] cur_start_q, cur_start_d;
  logic [LW-1:0] cur_len_q, cur_len_d;
  logic          ok_q, ok_d;
  logic [7:0]    cap_q, cap_d;

  logic          full;
  logic          line_end;
  logic          blank;
  logic          take;
  logic          do_close;
  logic          mem_we;
  logic [31:0]   rng_next;

  logic [EW-1:0] mem_q [MAX_WORDS];
  logic [EW-1:0] rd_q;

  logic          mod_done;
  logic [AW-1:0] mod_rem;

  logic          out_valid_q, out_valid_d;
  logic          out_ok_q;
  logic [AW-1:0] out_index_q;
  logic [OB-1:0] out_offset_q;
  logic [LW-1:0] out_length_q;

  logic [7:0]    cap_m1;
  logic [LW-1:0] rd_len;
  logic [LW-1:0] len_sel;

  // byte classes and scanner gating
  assign full     = (total_q == TW'(MAX_WORDS));
  assign line_end = (data_byte_i == liwp_pkg::CHAR_LF) || (data_byte_i == liwp_pkg::CHAR_CR);
  assign blank    = line_end || (data_byte_i == liwp_pkg::CHAR_SP)
                 || (data_byte_i == liwp_pkg::CHAR_TAB);
  assign take     = cmd_i.take_byte && !full && !pos_q[OB];
  assign do_close = cmd_i.end_load || (take && inside_q && line_end);
  assign mem_we   = do_close && inside_q && !full;
  assign rng_next = liwp_pkg::rng_step(rng_q);

  // scanner, random state and pick context
  always_comb begin
    rng_d       = rng_q;
    total_d     = total_q;
    pos_d       = pos_q;
    inside_d    = inside_q;
    cur_start_d = cur_start_q;
    cur_len_d   = cur_len_q;
    ok_d        = ok_q;
    cap_d       = cap_q;
    if (cmd_i.start_load) begin
      rng_d       = liwp_pkg::rng_seed(rng_q, seed_time_i);
      total_d     = '0;
      pos_d       = '0;
      inside_d    = 1'b0;
      cur_start_d = '0;
      cur_len_d   = '0;
    end
    if (take) begin
      pos_d = pos_q + 1'b1;
      if (!inside_q) begin
        if (!blank) begin
          inside_d    = 1'b1;
          cur_start_d = pos_q[OB-1:0];
          cur_len_d   = LW'(1);
        end
      end else if (!line_end && (cur_len_q < LW'(MAX_WORD_LEN))) begin
        cur_len_d = cur_len_q + 1'b1;
      end
    end
    if (do_close) begin
      inside_d = 1'b0;
    end
    if (mem_we) begin
      total_d = total_q + 1'b1;
    end
    if (cmd_i.pick_go) begin
      rng_d = rng_next;
      ok_d  = 1'b1;
      cap_d = dest_capacity_i;
    end
    if (cmd_i.pick_fail) begin
      ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q       <= liwp_pkg::RNG_RESET;
      total_q     <= '0;
      pos_q       <= '0;
      inside_q    <= 1'b0;
      cur_start_q <= '0;
      cur_len_q   <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rng_q       <= rng_d;
      total_q     <= total_d;
      pos_q       <= pos_d;
      inside_q    <= inside_d;
      cur_start_q <= cur_start_d;
      cur_len_q   <= cur_len_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q <= cap_d;
  end

  // word table: start offset and length per entry
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[total_q[AW-1:0]] <= {cur_start_q, cur_len_q};
    end
    if (cmd_i.mem_read) begin
      rd_q <= mem_q[mod_rem];
    end
  end

  // random value modulo word count
  liwp_mod #(
    .DW (liwp_pkg::RNG_W),
    .TW (TW),
    .AW (AW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.pick_go),
    .dividend_i (rng_next),
    .divisor_i  (total_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // length clamped to capacity minus one
  assign cap_m1 = cap_q - 8'd1;
  assign rd_len = rd_q[LW-1:0];
  always_comb begin
    if (8'(rd_len) > cap_m1) begin
      len_sel = cap_m1[LW-1:0];
    end else begin
      len_sel = rd_len;
    end
  end

  // result register
  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ok_q <= ok_q;
      if (ok_q) begin
        out_index_q  <= mod_rem;
        out_offset_q <= rd_q[EW-1:LW];
        out_length_q <= len_sel;
      end else begin
        out_index_q  <= '0;
        out_offset_q <= '0;
        out_length_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_ok_o     = out_ok_q;
  assign out_index_o  = out_index_q;
  assign out_offset_o = out_offset_q;
  assign out_length_o = out_length_q;

  // status to the sequencer
  assign stat_o.pick_bad = (dest_capacity_i < 8'd2) || (total_q == '0);
  assign stat_o.mod_done = mod_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== hw/rtl/line_index_random_word_picker.sv =====
// ----------------------------------------------------------------------------
// line_index_random_word_picker
// Builds a line index of a streamed vocabulary (start offset and saturated
// length of each word) and picks a word with an xorshift32 generator.
// ----------------------------------------------------------------------------
//   channel  dir  handshake        payload
//   in_i     in   valid/ready      action, data_byte, dest_capacity
//   out_o    out  valid/ready      ok, word_index, word_offset, word_length
//   apb      in   psel/penable     seed_time at address 0
//
// Start, byte and end items are taken back to back in the idle state.
// A pick runs through the bit-serial remainder unit, then one word table read
// and the result register load; a failed pick skips to the result load
// and leaves the random state as is.
// A held result does not block bytes; the next pick waits for the slot.
// Reset is asynchronous; the word table has no reset and needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module line_index_random_word_picker #(
  parameter int unsigned MAX_WORDS    = liwp_pkg::DEF_MAX_WORDS,
  parameter int unsigned MAX_WORD_LEN = liwp_pkg::DEF_MAX_WORD_LEN,
  parameter int unsigned OFFSET_BITS  = liwp_pkg::DEF_OFFSET_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  liwp_in_if.sink                             in_i,
  liwp_out_if.source                          out_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [liwp_pkg::APB_AW-1:0]    paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int unsigned AW = $clog2(MAX_WORDS);
  localparam int unsigned LW = $clog2(MAX_WORD_LEN + 1);

  liwp_pkg::cmd_t  cmd;
  liwp_pkg::stat_t stat;
  logic [31:0]     seed_q;
  logic            reg_hit;

  // register port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[liwp_pkg::APB_AW-1] == liwp_pkg::REG_SEED);
  assign prdata  = reg_hit ? seed_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (psel && penable && pwrite && reg_hit) begin
      seed_q <= pwdata;
    end
  end

  // sequencer
  liwp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath
  liwp_dp #(
    .MAX_WORDS    (MAX_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .OFFSET_BITS  (OFFSET_BITS),
    .AW           (AW),
    .LW           (LW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .data_byte_i     (in_i.data_byte),
    .dest_capacity_i (in_i.dest_capacity),
    .seed_time_i     (seed_q),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_ok_o        (out_o.ok),
    .out_index_o     (out_o.word_index),
    .out_offset_o    (out_o.word_offset),
    .out_length_o    (out_o.word_length)
  );

endmodule

`default_nettype wire

// ===== tb/tb_line_index_random_word_picker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_index_random_word_picker
// Self-checking bench for the line index word picker. Command items go in over
// a valid/ready channel and the seed register is set over the APB port. An
// in-bench index and xorshift model predicts each pick result the script does
// not list. Parts: a directed script, a forced zero seed, a long output hold-off
// and random load/pick sessions, most with random gaps on both channels.
// ----------------------------------------------------------------------------

module tb_line_index_random_word_picker;

  localparam int WORDS_CAP     = liwp_pkg::DEF_MAX_WORDS;
  localparam int POS_END       = 1 << liwp_pkg::DEF_OFFSET_BITS;
  localparam int TOTAL_ITEMS   = 1500;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 6_000_000;
  localparam int SEED_BYTE     = 4 * int'(liwp_pkg::REG_SEED);
  localparam logic [liwp_pkg::APB_AW-1:0] SEED_ADDR = SEED_BYTE[liwp_pkg::APB_AW-1:0];

  // one pick result
  typedef struct packed {
    logic        ok;
    logic [12:0] idx;
    logic [19:0] off;
    logic [6:0]  len;
  } pick_t;

  localparam pick_t REFUSED = '0;

  // one row of the directed script
  typedef struct {
    liwp_pkg::action_e act;
    logic [7:0]        data;
    logic [7:0]        cap;
    bit                typed;
    pick_t             want;
  } step_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [liwp_pkg::APB_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  liwp_in_if  in_if ();
  liwp_out_if out_if ();

  line_index_random_word_picker uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // line index model state
  logic [19:0] lx_start [WORDS_CAP];
  logic [6:0]  lx_len   [WORDS_CAP];
  logic [13:0] lx_words     = '0;
  logic [31:0] lx_rng       = liwp_pkg::RNG_RESET;
  logic [20:0] lx_pos       = '0;
  logic        lx_open      = 1'b0;
  logic [19:0] lx_cur_start = '0;
  logic [6:0]  lx_cur_len   = '0;
  logic [31:0] lx_seed      = '0;

  pick_t picks_due [$];

  // run control and statistics
  bit src_gaps     = 1'b1;
  bit sink_stalls  = 1'b1;
  bit hold_request = 1'b0;
  int errors        = 0;
  int items_done    = 0;
  int picks_seen    = 0;
  int picks_refused = 0;
  int peak_words    = 0;
  int deepest_off   = 0;
  int cycle_cnt     = 0;

  // directed script: reset state, blanks, word edges, capacity limits
  step_row_t script [25] = '{
    '{liwp_pkg::ACT_PICK,  8'h00, 8'hFF, 1'b1, REFUSED},
    '{liwp_pkg::ACT_BYTE,  8'h20, 8'h00, 1'b0, REFUSED},
    '{liwp_pkg::ACT_BYTE,  8'h09, 8'hFF, 1'b0, REFUSED},
    '{liwp_pkg::ACT_BYTE,  8'h0D, 8'h55, 1'b0, REFUSED},
    '{liwp_pkg::ACT_BYTE,  8'h0A, 8'hAA, 1'b0, REFUSED},
    '{liwp_pkg::ACT_BYTE,  8'h61, 8'h00, 1'b0, REFUSED},
    '{liwp_pkg::ACT_BYTE,  8'h20, 8'h00, 1'b0, REFUSED},
    '{liwp_pkg::ACT_BYTE,  8'h09, 8'h00, 1'b0, REFUSED},
    '{liwp_pkg::ACT_BYTE,  8'hFF, 8'h00, 1'b0, REFUSED},
    '{liwp_pkg::ACT_BYTE,  8'h0D, 8'h00, 1'b0, REFUSED},
    '{liwp_pkg::ACT_PICK,  8'h00, 8'hFF, 1'b1, '{1'b1, 13'd0, 20'd4, 7'd4}},
    '{liwp_pkg::ACT_PICK,  8'hFF, 8'h02, 1'b1, '{1'b1, 13'd0, 20'd4, 7'd1}},
    '{liwp_pkg::ACT_PICK,  8'h00, 8'h01, 1'b1, REFUSED},
    '{liwp_pkg::ACT_PICK,  8'h00, 8'h00, 1'b1, REFUSED},
    '{liwp_pkg::ACT_BYTE,  8'h00, 8'h00, 1'b0, REFUSED},
    '{liwp_pkg::ACT_PICK,  8'h00, 8'h80, 1'b1, '{1'b1, 13'd0, 20'd4, 7'd4}},
    '{liwp_pkg::ACT_END,   8'hFF, 8'hFF, 1'b0, REFUSED},
    '{liwp_pkg::ACT_END,   8'h00, 8'h00, 1'b0, REFUSED},
    '{liwp_pkg::ACT_PICK,  8'h00, 8'h7F, 1'b0, REFUSED},
    '{liwp_pkg::ACT_PICK,  8'h00, 8'h03, 1'b0, REFUSED},
    '{liwp_pkg::ACT_START, 8'hFF, 8'hFF, 1'b0, REFUSED},
    '{liwp_pkg::ACT_PICK,  8'h00, 8'hFF, 1'b1, REFUSED},
    '{liwp_pkg::ACT_BYTE,  8'h7F, 8'h00, 1'b0, REFUSED},
    '{liwp_pkg::ACT_BYTE,  8'h0A, 8'h00, 1'b0, REFUSED},
    '{liwp_pkg::ACT_PICK,  8'h00, 8'hFF, 1'b1, '{1'b1, 13'd0, 20'd0, 7'd1}}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // mismatch report
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  // xorshift32 advance, zero replaced
  function automatic logic [31:0] xs_next(input logic [31:0] s);
    logic [31:0] a;
    logic [31:0] c;
    logic [31:0] d;
    a = s ^ {s[18:0], 13'd0};
    c = a ^ {17'd0, a[31:17]};
    d = c ^ {c[26:0], 5'd0};
    return (d == '0) ? liwp_pkg::RNG_ZERO_FIX : d;
  endfunction

  // store the open word if there is room
  function automatic void index_close();
    if (lx_open && int'(lx_words) < WORDS_CAP) begin
      lx_start[lx_words[12:0]] = lx_cur_start;
      lx_len[lx_words[12:0]]   = lx_cur_len;
      lx_words++;
      if (int'(lx_words) > peak_words) peak_words = int'(lx_words);
    end
    lx_open = 1'b0;
  endfunction

  // apply one accepted item to the index; returns 1 with the pick result
  function automatic bit index_track(input liwp_pkg::action_e act, input logic [7:0] b,
                                     input logic [7:0] cap, output pick_t res);
    bit line_end;
    bit blank;
    int unsigned sel;
    int unsigned stored;
    int unsigned lim;
    res = REFUSED;
    case (act)
      liwp_pkg::ACT_START: begin
        lx_rng = lx_rng ^ {lx_seed[15:0], 16'd0} ^ {3'd0, lx_seed[31:3]}
               ^ liwp_pkg::SEED_MIX;
        if (lx_rng == '0) lx_rng = liwp_pkg::RNG_RESET;
        lx_words     = '0;
        lx_pos       = '0;
        lx_open      = 1'b0;
        lx_cur_start = '0;
        lx_cur_len   = '0;
        return 1'b0;
      end
      liwp_pkg::ACT_BYTE: begin
        line_end = (b == liwp_pkg::CHAR_LF) || (b == liwp_pkg::CHAR_CR);
        blank    = line_end || (b == liwp_pkg::CHAR_SP) || (b == liwp_pkg::CHAR_TAB);
        if (int'(lx_words) >= WORDS_CAP || int'(lx_pos) >= POS_END) return 1'b0;
        if (!lx_open) begin
          if (!blank) begin
            lx_open      = 1'b1;
            lx_cur_start = lx_pos[19:0];
            lx_cur_len   = 7'd1;
          end
        end else if (line_end) begin
          index_close();
        end else if (int'(lx_cur_len) < liwp_pkg::DEF_MAX_WORD_LEN) begin
          lx_cur_len++;
        end
        lx_pos++;
        return 1'b0;
      end
      liwp_pkg::ACT_END: begin
        index_close();
        return 1'b0;
      end
      liwp_pkg::ACT_PICK: begin
        if (cap < 8'd2 || lx_words == '0) return 1'b1;
        lx_rng = xs_next(lx_rng);
        sel    = lx_rng % 32'(lx_words);
        stored = 32'(lx_len[sel]);
        lim    = int'(cap) - 1;
        res.ok  = 1'b1;
        res.idx = sel[12:0];
        res.off = lx_start[sel];
        res.len = 7'((stored > lim) ? lim : stored);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // gap lengths: mostly short, a few long
  function automatic int idle_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 48);
    return $urandom_range(1, 3);
  endfunction

  // vocabulary byte that is not a line end (and not blank when leading)
  function automatic logic [7:0] word_byte(input bit lead);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255));
    while (v == liwp_pkg::CHAR_LF || v == liwp_pkg::CHAR_CR ||
           (lead && (v == liwp_pkg::CHAR_SP || v == liwp_pkg::CHAR_TAB)));
    return v;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0: return liwp_pkg::CHAR_SP;
      1: return liwp_pkg::CHAR_TAB;
      2: return liwp_pkg::CHAR_CR;
      default: return liwp_pkg::CHAR_LF;
    endcase
  endfunction

  // capacity: mostly usable, some refused, some that clamp the length
  function automatic logic [7:0] pick_cap();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 1));
      1, 2, 3: return 8'($urandom_range(2, 12));
      4: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // offer one item and wait for it to be taken
  task automatic send_item(input liwp_pkg::action_e act, input logic [7:0] b,
                           input logic [7:0] cap,
                           input bit typed = 1'b0, input pick_t want = REFUSED);
    pick_t got;
    in_if.valid         <= 1'b1;
    in_if.action        <= act;
    in_if.data_byte     <= b;
    in_if.dest_capacity <= cap;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    items_done++;
    if (index_track(act, b, cap, got)) picks_due.push_back(typed ? want : got);
    if (src_gaps && $urandom_range(0, 2) == 0) begin
      in_if.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk_i);
    end
  endtask

  // one word, optionally closed by CR or LF
  task automatic send_word(input int len, input bit close);
    for (int k = 0; k < len; k++)
      send_item(liwp_pkg::ACT_BYTE, word_byte(k == 0), 8'($urandom_range(0, 255)));
    if (close)
      send_item(liwp_pkg::ACT_BYTE,
                $urandom_range(0, 1) ? liwp_pkg::CHAR_LF : liwp_pkg::CHAR_CR,
                8'($urandom_range(0, 255)));
  endtask

  task automatic send_picks(input int n);
    repeat (n) send_item(liwp_pkg::ACT_PICK, 8'($urandom_range(0, 255)), pick_cap());
  endtask

  // drop valid and wait until every pick has answered and the block is quiet
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // seed_time write, then read back
  task automatic seed_write(input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_ADDR;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    lx_seed = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== v) flag_mismatch("seed_time readback", prdata, v);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: ready with random stalls, plus the long hold-off on request
  initial begin
    int held;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_if.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
        hold_request = 1'b0;
        out_if.ready <= 1'b1;
      end else if (!sink_stalls || $urandom_range(0, 3) != 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end
    end
  end

  // compare each taken result with the oldest pending pick
  initial begin
    pick_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (picks_due.size() == 0) begin
          flag_mismatch("result with no pick pending", 32'(out_if.word_index), 32'd0);
        end else begin
          want = picks_due.pop_front();
          picks_seen++;
          if (!want.ok) picks_refused++;
          if (int'(want.off) > deepest_off) deepest_off = int'(want.off);
          if (out_if.ok !== want.ok)
            flag_mismatch("ok", 32'(out_if.ok), 32'(want.ok));
          if (out_if.word_index !== want.idx)
            flag_mismatch("word_index", 32'(out_if.word_index), 32'(want.idx));
          if (out_if.word_offset !== want.off)
            flag_mismatch("word_offset", 32'(out_if.word_offset), 32'(want.off));
          if (out_if.word_length !== want.len)
            flag_mismatch("word_length", 32'(out_if.word_length), 32'(want.len));
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d picks pending", cycle_cnt, picks_due.size());
    $display("Test completed with failures");
    $finish;
  end

  // stimulus
  initial begin
    logic [31:0] target;
    logic [31:0] zseed;
    int session;
    int wlen;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.action        = liwp_pkg::ACT_START;
    in_if.data_byte     = '0;
    in_if.dest_capacity = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed script, bytes indexed straight from reset
    foreach (script[i])
      send_item(script[i].act, script[i].data, script[i].cap, script[i].typed, script[i].want);

    // step the generator until a seed exists that folds the state to zero
    zseed = '0;
    for (int tries = 0; tries < 64; tries++) begin
      target      = lx_rng ^ liwp_pkg::SEED_MIX;
      zseed       = '0;
      zseed[18:3] = target[15:0];
      zseed[2:0]  = target[18:16];
      zseed[31:22] = target[28:19] ^ target[9:0];
      if (({zseed[15:0], 16'd0} ^ (zseed >> 3)) == target) break;
      send_item(liwp_pkg::ACT_PICK, 8'h00, 8'hFF);
    end
    wait_idle();
    seed_write(zseed);
    send_item(liwp_pkg::ACT_START, 8'h00, 8'h00);
    repeat (4) send_word($urandom_range(1, 6), 1'b1);
    send_picks(6);

    // output held off while picks keep coming
    sink_stalls  = 1'b0;
    hold_request = 1'b1;
    repeat (6) send_item(liwp_pkg::ACT_PICK, 8'h00, 8'hFF);
    sink_stalls = 1'b1;

    // random load and pick sessions
    session = 0;
    while (items_done < TOTAL_ITEMS) begin
      if (session % 4 == 3) begin
        wait_idle();
        case ($urandom_range(0, 3))
          0: seed_write('0);
          1: seed_write('1);
          default: seed_write($urandom);
        endcase
      end
      src_gaps    = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) != 0)
        send_item(liwp_pkg::ACT_START, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 12)) begin
        repeat ($urandom_range(0, 2))
          send_item(liwp_pkg::ACT_BYTE, blank_byte(), 8'($urandom_range(0, 255)));
        wlen = ($urandom_range(0, 14) == 0) ? $urandom_range(90, 110) : $urandom_range(1, 8);
        send_word(wlen, $urandom_range(0, 9) != 0);
        if ($urandom_range(0, 3) == 0) send_picks(1);
      end
      if ($urandom_range(0, 1) == 0)
        send_item(liwp_pkg::ACT_END, 8'($urandom_range(0, 255)), 8'h00);
      // noise: any action, any field values
      repeat ($urandom_range(0, 3))
        send_item(liwp_pkg::action_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      send_picks($urandom_range(1, 4));
      session++;
    end

    wait_idle();
    $display("run covered %0d items in %0d sessions, %0d pick results checked (%0d refused)",
             items_done, session, picks_seen, picks_refused);
    $display("index grew to %0d words, deepest word offset returned %0d",
             peak_words, deepest_off);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
